/* hdl/cicd_pkg.sv */
// Shared types and constants for the concatenated inner-code block decoder.
`timescale 1ns / 1ps

package cicd_pkg;

   // Physical qubits held in one block word
   localparam int MAX_QUBITS = 64;
   localparam int FLIP_W     = 64;
   localparam logic [FLIP_W-1:0] QUBIT_MASK =
      (MAX_QUBITS >= FLIP_W) ? {FLIP_W{1'b1}} : ((FLIP_W'(1) << MAX_QUBITS) - FLIP_W'(1));

   // Shor block side: 4-bit register, so up to 15
   localparam int SIDE_W     = 4;
   localparam int SIDE_COUNT = 1 << SIDE_W;
   localparam logic [SIDE_W-1:0] SHOR_SIDE_RESET = 4'd3;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOR_SIDE = 2'd1;

   typedef enum logic [1:0] {
      MODE_SHOR_X = 2'd0,
      MODE_SHOR_Z = 2'd1,
      MODE_STEANE = 2'd2,
      MODE_FOUR22 = 2'd3
   } code_mode_type;

   typedef struct packed {
      logic [FLIP_W-1:0] qubit_flips;
      logic              prior_flip;
   } req_word_type;

   typedef struct packed {
      logic              logical_flip;
      logic [FLIP_W-1:0] corrected_flips;
   } rsp_word_type;

endpackage

/* hdl/cicd_decode.sv */
// Combinational decode of one block word for all four inner codes.
`timescale 1ns / 1ps

module cicd_decode
   import cicd_pkg::*;
(
   input  req_word_type      in_word,
   input  code_mode_type     code_mode,
   input  logic [SIDE_W-1:0] shor_side,
   output rsp_word_type      out_word
);

   localparam int IDX_W = 8;          // holds j + side*k for side up to 15
   localparam int QIDX_W = $clog2(FLIP_W);

   // Parity of per-block majorities (X) and majority over per-block parities (Z) for a fixed side
   function automatic logic [1:0] shor_vote(input logic [FLIP_W-1:0] q,
                                            input logic [SIDE_W-1:0] side);
      logic              vote_x;
      logic [SIDE_W-1:0] odd;
      logic [SIDE_W-1:0] cnt;
      logic              par;
      logic [IDX_W-1:0]  idx;
      vote_x = 1'b0;
      odd    = '0;
      for (int k = 0; k < SIDE_COUNT - 1; k++) begin
         cnt = '0;
         par = 1'b0;
         for (int j = 0; j < SIDE_COUNT - 1; j++) begin
            idx = IDX_W'(j) + IDX_W'(side) * IDX_W'(k);
            if ((j < int'(side)) && (int'(idx) < MAX_QUBITS)) begin
               cnt = cnt + {{(SIDE_W-1){1'b0}}, q[idx[QIDX_W-1:0]]};
               par = par ^ q[idx[QIDX_W-1:0]];
            end
         end
         if (k < int'(side)) begin
            if (cnt > (side >> 1))
               vote_x = ~vote_x;
            odd = odd + {{(SIDE_W-1){1'b0}}, par};
         end
      end
      return {vote_x, (odd > (side >> 1))};
   endfunction

   logic [FLIP_W-1:0]     q_in;
   logic [SIDE_COUNT-1:0] x_by_side;
   logic [SIDE_COUNT-1:0] z_by_side;

   assign q_in = in_word.qubit_flips & QUBIT_MASK;

   // One fixed vote network per block side; side zero has no blocks
   assign x_by_side[0] = 1'b0;
   assign z_by_side[0] = 1'b0;
   for (genvar s = 1; s < SIDE_COUNT; s++) begin : g_side
      assign {x_by_side[s], z_by_side[s]} = shor_vote(q_in, SIDE_W'(s));
   end

   // Mode select, Steane and 4-2-2 correction
   always_comb begin
      logic [2:0]        syn;
      logic [1:0]        chk;
      logic [FLIP_W-1:0] q;
      q   = q_in;
      syn = '0;
      chk = '0;
      out_word.logical_flip = 1'b0;
      unique case (code_mode)
         MODE_SHOR_X: begin
            out_word.logical_flip = x_by_side[shor_side];
         end
         MODE_SHOR_Z: begin
            out_word.logical_flip = z_by_side[shor_side];
         end
         MODE_STEANE: begin
            syn = {^q_in[6:3], q_in[1] ^ q_in[2] ^ q_in[5] ^ q_in[6],
                   q_in[0] ^ q_in[2] ^ q_in[4] ^ q_in[6]};
            if (syn != 3'd0)
               q = q_in ^ (FLIP_W'(1) << (syn - 3'd1));
            out_word.logical_flip = in_word.prior_flip ^ (^q[6:0]);
         end
         MODE_FOUR22: begin
            chk = {q_in[0] ^ q_in[1], q_in[0] ^ q_in[2]};
            unique case (chk)
               2'b01:   q[2] = ~q_in[2];
               2'b10:   q[1] = ~q_in[1];
               2'b11:   q[0] = ~q_in[0];
               default: q    = q_in;
            endcase
            out_word.logical_flip = in_word.prior_flip ^ q[0] ^ q[1];
         end
         default: out_word.logical_flip = 1'b0;
      endcase
      out_word.corrected_flips = q & QUBIT_MASK;
   end

endmodule

/* hdl/concat_inner_code_decoder.sv */
// Top level: input register, decode, result register and configuration registers.
`timescale 1ns / 1ps
// Pipeline: a word accepted into the input register is decoded there and is offered on rsp
// once it moves into the result register.
// Throughput: one word per cycle while rsp_ready stays high; a stalled result
// register holds the input register, so the block fills two words deep.
// Reset (synchronous, active high) empties both stages and sets code_mode to
// Steane and shor_side to 3.

module concat_inner_code_decoder
   import cicd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   code_mode_type     code_mode_ff, code_mode_in;
   logic [SIDE_W-1:0] shor_side_ff, shor_side_in;
   logic              in_valid_ff, in_valid_in;
   req_word_type      in_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff;
   rsp_word_type      dec_word;
   logic              advance;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      code_mode_in = code_mode_ff;
      shor_side_in = shor_side_ff;
      if (csr_valid) begin
         if (csr_index == CSR_CODE_MODE)
            code_mode_in = code_mode_type'(csr_data[1:0]);
         else if (csr_index == CSR_SHOR_SIDE)
            shor_side_in = csr_data[SIDE_W-1:0];
      end
   end

   // Stage handshake: the input stage moves whenever the result slot frees
   assign advance     = ~rsp_valid_ff | rsp_ready;
   assign req_ready   = ~in_valid_ff | advance;
   assign in_valid_in = (in_valid_ff & ~advance) | req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   cicd_decode u_decode (
      .in_word   (in_word_ff),
      .code_mode (code_mode_ff),
      .shor_side (shor_side_ff),
      .out_word  (dec_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         code_mode_ff <= MODE_STEANE;
         shor_side_ff <= SHOR_SIDE_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         code_mode_ff <= code_mode_in;
         shor_side_ff <= shor_side_in;
         in_valid_ff  <= req_ready ? in_valid_in : in_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready)
         in_word_ff <= req_word;
      if (advance && in_valid_ff)
         rsp_word_ff <= dec_word;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   a_reset_cfg: assert property (@(posedge clock)
      reset |=> (code_mode_ff == MODE_STEANE) && (shor_side_ff == SHOR_SIDE_RESET))
      else $error("configuration not at reset values after reset");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   a_moves_on: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> rsp_valid_ff)
      else $error("decoded word lost on its way to the result register");

   a_single_fix: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> ($countones(dec_word.corrected_flips ^
                                  (in_word_ff.qubit_flips & QUBIT_MASK)) <= 1))
      else $error("correction touched more than one qubit");

   a_shor_no_fix: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (code_mode_ff == MODE_SHOR_X || code_mode_ff == MODE_SHOR_Z))
      |-> (dec_word.corrected_flips == (in_word_ff.qubit_flips & QUBIT_MASK)))
      else $error("Shor mode changed the block bits");

endmodule
